### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int PRIO_W  = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;   // width of the reported entry count

    typedef logic signed [PRIO_W-1:0]  prio_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

    // One stored entry as it moves between cells
    typedef struct packed {
        prio_t  prio;
        value_t value;
    } entry_t;

    // Registered response word
    typedef struct packed {
        status_t        status;
        prio_t          popped_priority;
        value_t         popped_value;
        logic           head_valid;
        prio_t          head_priority;
        value_t         head_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_word_t;

endpackage

`default_nettype wire

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels carrying queue requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   cmd;
    prio_t  priority_req;
    value_t value;

    modport source (output valid, output cmd, output priority_req, output value,
                    input ready);
    modport sink   (input valid, input cmd, input priority_req, input value,
                    output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    prio_t              popped_priority;
    value_t             popped_value;
    logic               head_valid;
    prio_t              head_priority;
    value_t             head_value;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output popped_priority,
                    output popped_value, output head_valid, output head_priority,
                    output head_value, output entry_count, input ready);
    modport sink   (input valid, input status, input popped_priority,
                    input popped_value, input head_valid, input head_priority,
                    input head_value, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares against the pushed entry and
// keeps, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_gt,
    input  wire entry_t    right_entry,
    output entry_t         entry,
    output logic           gt
);

    entry_t entry_reg;
    entry_t entry_next;

    // stays ahead of the pushed entry only if strictly higher priority
    assign gt = occupied && (entry_reg.prio > new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            if (!gt)
            begin
                entry_next = left_gt ? new_entry : left_entry;
            end
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held sorted in a chain of compare-and-shift cells.
//
//   channel  dir  contents
//   req      in   cmd, priority_req, value
//   rsp      out  status, popped_*, head_valid, head_*, entry_count
//
// A request is applied to every cell in the cycle it is accepted; its
// response word is registered and shows on rsp the next cycle.
// One request per cycle sustained while rsp.ready is high; the single compare per cell sets the path.
// req.ready stays high while the response register is empty or being taken.
// Reset clears the entry count; cell contents are don't-care until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    rsp_word_t     rsp_reg;
    rsp_word_t     rsp_next;

    logic      accept;
    logic      is_push;
    logic      full;
    logic      empty;
    logic      do_push;
    logic      do_pop;
    cell_ctl_t ctl;
    entry_t    new_entry;
    entry_t    head_next;

    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_gt;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_push   = (req.cmd == CMD_PUSH);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = accept && is_push && !full;
    assign do_pop    = accept && !is_push && !empty;

    assign ctl.push        = do_push;
    assign ctl.pop         = do_pop;
    assign new_entry.prio  = req.priority_req;
    assign new_entry.value = req.value;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_gt;

            if (gi == 0)
            begin : g_head
                // nothing ahead of the head: it behaves as an infinite priority
                assign left_e  = new_entry;
                assign left_gt = 1'b1;
            end
            else
            begin : g_mid
                assign left_e  = cell_entry[gi-1];
                assign left_gt = cell_gt[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CW'(gi) < count_reg),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_gt     (left_gt),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // head as it will stand after this request
    always_comb
    begin
        head_next = cell_entry[0];
        if (do_push)
        begin
            head_next = cell_gt[0] ? cell_entry[0] : new_entry;
        end
        else if (do_pop)
        begin
            head_next = cell_entry[1];
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (accept)
        begin
            rsp_next.status          = STATUS_OK;
            if (is_push && full)
            begin
                rsp_next.status = STATUS_FULL;
            end
            else if (!is_push && empty)
            begin
                rsp_next.status = STATUS_EMPTY;
            end
            rsp_next.popped_priority = do_pop ? cell_entry[0].prio : '0;
            rsp_next.popped_value    = do_pop ? cell_entry[0].value : '0;
            rsp_next.head_valid      = (count_next != '0);
            rsp_next.head_priority   = (count_next != '0) ? head_next.prio : '0;
            rsp_next.head_value      = (count_next != '0) ? head_next.value : '0;
            rsp_next.entry_count     = COUNT_W'(count_next);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = rsp_reg.status;
    assign rsp.popped_priority = rsp_reg.popped_priority;
    assign rsp.popped_value    = rsp_reg.popped_value;
    assign rsp.head_valid      = rsp_reg.head_valid;
    assign rsp.head_priority   = rsp_reg.head_priority;
    assign rsp.head_value      = rsp_reg.head_value;
    assign rsp.entry_count     = rsp_reg.entry_count;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
        else $error("head lower priority than second entry");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_push && full |=> count_reg == $past(count_reg))
        else $error("push on full queue changed the count");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove one entry");

endmodule

`default_nettype wire
